FILE: sv/wsos_pkg.sv
// ---------------------------------------------------------------------------
// wsos_pkg
// Shared types, constants and tables of the weighted sensor steering block.
// ---------------------------------------------------------------------------
`default_nettype none

package wsos_pkg;

    // field and register widths
    localparam int IDX_W   = 4;
    localparam int VAL_W   = 11;
    localparam int DIST_W  = 13;
    localparam int THR_W   = 11;
    localparam int SPD_W   = 14;
    localparam int OSPD_W  = 15;
    localparam int TOT_W   = 19;
    localparam int WGT_W   = 10;
    localparam int MOD_W   = 9;
    localparam int QUO_W   = 8;
    localparam int DIR_W   = 2;
    localparam int CIDX_W  = 3;
    localparam int CDAT_W  = 16;
    localparam int PC_W    = 3;

    localparam int NUM_SENSORS_DEF = 16;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_MIN_DIST  = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_THRESHOLD = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_CORNER    = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_MAX_SPEED = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_TURN_SPD  = 3'd4;

    // configuration reset values
    localparam logic [DIST_W-1:0] MIN_DIST_RST  = 13'd717;
    localparam logic [THR_W-1:0]  THRESHOLD_RST = 11'd100;
    localparam logic [THR_W-1:0]  CORNER_RST    = 11'd400;
    localparam logic [SPD_W-1:0]  MAX_SPEED_RST = 14'd10500;
    localparam logic [SPD_W-1:0]  TURN_SPD_RST  = 14'd7350;

    // reading limits and saturated total
    localparam logic [VAL_W-1:0] VAL_FULL  = 11'd1024;
    localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

    // direction codes on the result port
    localparam logic [DIR_W-1:0] DIR_FWD    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_RIGHT  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_CORNER = 2'd3;

    // steering state, one-hot
    typedef enum logic [3:0] {
        ST_FWD    = 4'b0001,
        ST_LEFT   = 4'b0010,
        ST_RIGHT  = 4'b0100,
        ST_CORNER = 4'b1000
    } t_steer;

    // jump conditions of the microcode
    typedef enum logic [2:0] {
        C_NEVER     = 3'd0,
        C_NO_ACCEPT = 3'd1,
        C_SKIP      = 3'd2,
        C_DIV_MORE  = 3'd3,
        C_NOT_LAST  = 3'd4,
        C_OUT_FULL  = 3'd5,
        C_ALWAYS    = 3'd6
    } t_cond;

    // one control word
    typedef struct packed {
        logic            ready;
        logic            setup;
        logic            div;
        logic            accum;
        logic            decide;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_uop;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic accept;
        logic skip;
        logic div_more;
        logic not_last;
        logic out_full;
    } t_flags;

    // left weight of each sensor
    function automatic logic [WGT_W-1:0] weight_left(input logic [IDX_W-1:0] idx);
        logic [WGT_W-1:0] w;
        case (idx)
            4'd0:    w = 10'd150;
            4'd1:    w = 10'd200;
            4'd2:    w = 10'd300;
            4'd3:    w = 10'd600;
            default: w = 10'd0;
        endcase
        return w;
    endfunction

    // right weight of each sensor
    function automatic logic [WGT_W-1:0] weight_right(input logic [IDX_W-1:0] idx);
        logic [WGT_W-1:0] w;
        case (idx)
            4'd4:    w = 10'd600;
            4'd5:    w = 10'd300;
            4'd6:    w = 10'd200;
            4'd7:    w = 10'd150;
            default: w = 10'd0;
        endcase
        return w;
    endfunction

    // result code of a steering state
    function automatic logic [DIR_W-1:0] dir_code(input t_steer st);
        logic [DIR_W-1:0] d;
        case (st)
            ST_LEFT:   d = DIR_LEFT;
            ST_RIGHT:  d = DIR_RIGHT;
            ST_CORNER: d = DIR_CORNER;
            default:   d = DIR_FWD;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: sv/wsos_seq.sv
// ---------------------------------------------------------------------------
// wsos_seq
// Microcode sequencer: step counter, control word rom and conditional jumps.
// ---------------------------------------------------------------------------
`default_nettype none

module wsos_seq (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wsos_pkg::t_flags  i_flags,
    output wsos_pkg::t_uop    o_uop
);
    import wsos_pkg::*;

    // program steps
    localparam logic [PC_W-1:0] STEP_FETCH  = 3'd0;
    localparam logic [PC_W-1:0] STEP_SETUP  = 3'd1;
    localparam logic [PC_W-1:0] STEP_DIV    = 3'd2;
    localparam logic [PC_W-1:0] STEP_ACCUM  = 3'd3;
    localparam logic [PC_W-1:0] STEP_LAST   = 3'd4;
    localparam logic [PC_W-1:0] STEP_DECIDE = 3'd5;
    localparam logic [PC_W-1:0] STEP_LOOP   = 3'd6;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uop            uop;
    logic            taken;

    // control store
    always_comb begin
        uop = '{ready: 1'b0, setup: 1'b0, div: 1'b0, accum: 1'b0, decide: 1'b0,
                cond: C_ALWAYS, target: STEP_FETCH};
        case (r_pc)
            STEP_FETCH: begin
                uop.ready  = 1'b1;
                uop.cond   = C_NO_ACCEPT;
                uop.target = STEP_FETCH;
            end
            STEP_SETUP: begin
                uop.setup  = 1'b1;
                uop.cond   = C_SKIP;
                uop.target = STEP_LAST;
            end
            STEP_DIV: begin
                uop.div    = 1'b1;
                uop.cond   = C_DIV_MORE;
                uop.target = STEP_DIV;
            end
            STEP_ACCUM: begin
                uop.accum  = 1'b1;
                uop.cond   = C_NEVER;
            end
            STEP_LAST: begin
                uop.cond   = C_NOT_LAST;
                uop.target = STEP_FETCH;
            end
            STEP_DECIDE: begin
                uop.decide = 1'b1;
                uop.cond   = C_OUT_FULL;
                uop.target = STEP_DECIDE;
            end
            STEP_LOOP: begin
                uop.cond   = C_ALWAYS;
                uop.target = STEP_FETCH;
            end
            default: begin
                uop.cond   = C_ALWAYS;
                uop.target = STEP_FETCH;
            end
        endcase
    end

    // jump condition
    always_comb begin
        case (uop.cond)
            C_NEVER:     taken = 1'b0;
            C_NO_ACCEPT: taken = !i_flags.accept;
            C_SKIP:      taken = i_flags.skip;
            C_DIV_MORE:  taken = i_flags.div_more;
            C_NOT_LAST:  taken = i_flags.not_last;
            C_OUT_FULL:  taken = i_flags.out_full;
            C_ALWAYS:    taken = 1'b1;
            default:     taken = 1'b1;
        endcase
        n_pc = taken ? uop.target : r_pc + 3'd1;
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uop = uop;

endmodule

`default_nettype wire

FILE: sv/weighted_sensor_obstacle_steering.sv
// ---------------------------------------------------------------------------
// weighted_sensor_obstacle_steering
// Sums weighted sensor closeness per round and steers two wheels from it.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one sensor sample per item.
//   Samples of a round add to a left and a right total; the item with
//   i_last_sensor set closes the round and yields one result item on the
//   output channel (o_out_valid / i_out_ready); other items yield none.
//   Each sample runs fetch, setup, the 8-step serial divider, accumulate
//   and the last-item test, one at a time; one that adds nothing skips
//   divider and accumulate, and a closing item also passes decide and loop.
//   The result shows in the cycle after the decision step. It sits in an
//   output register, so the next round's samples are taken while it waits;
//   if it is still not taken when the next round closes, the sequencer holds
//   in its decision step until the receiver drains it.
//   Configuration writes (i_cfg_valid / o_cfg_ready) are taken every cycle
//   out of reset and are meant for idle time only.
//   Reset brings configuration to defaults, clears totals, sets the
//   steering state to forward and empties the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module weighted_sensor_obstacle_steering #(
    parameter int NUM_SENSORS = wsos_pkg::NUM_SENSORS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // configuration
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [wsos_pkg::CIDX_W-1:0]         i_cfg_index,
    input  wire  [wsos_pkg::CDAT_W-1:0]         i_cfg_data,
    // sample items
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire  [wsos_pkg::IDX_W-1:0]          i_sensor_index,
    input  wire  [wsos_pkg::VAL_W-1:0]          i_sensor_value,
    input  wire                                 i_last_sensor,
    // result items
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic signed [wsos_pkg::OSPD_W-1:0]  o_left_speed,
    output logic signed [wsos_pkg::OSPD_W-1:0]  o_right_speed,
    output logic [wsos_pkg::DIR_W-1:0]          o_direction_state
);
    import wsos_pkg::*;

    // configuration registers
    logic [DIST_W-1:0] r_min_dist;
    logic [THR_W-1:0]  r_threshold;
    logic [THR_W-1:0]  r_corner;
    logic [SPD_W-1:0]  r_max_speed;
    logic [SPD_W-1:0]  r_turn_speed;

    // item and datapath registers
    logic [IDX_W-1:0]  r_idx;
    logic [VAL_W-1:0]  r_val;
    logic              r_last;
    logic [DIST_W-1:0] r_rem;
    logic [QUO_W-1:0]  r_quo;
    logic [2:0]        r_cnt;
    logic [TOT_W-1:0]  r_lt;
    logic [TOT_W-1:0]  r_rt;
    t_steer            r_steer;
    logic              r_out_valid;
    logic [OSPD_W-1:0] r_ls;
    logic [OSPD_W-1:0] r_rs;
    logic [DIR_W-1:0]  r_dir;

    t_uop              uop;
    t_flags            flags;

    logic              accept;
    logic              out_full;
    logic              do_decide;
    logic [VAL_W-1:0]  val_sat;
    logic [VAL_W-1:0]  near;
    logic [DIST_W-1:0] distance;
    logic              skip;
    logic [DIST_W:0]   rem2;
    logic              ge;
    logic [DIST_W:0]   rem_sub;
    logic [MOD_W-1:0]  modif;
    logic [TOT_W-1:0]  prod_l;
    logic [TOT_W-1:0]  prod_r;
    logic [TOT_W:0]    sum_l;
    logic [TOT_W:0]    sum_r;
    logic [TOT_W-1:0]  thr;
    logic [TOT_W-1:0]  lim;
    logic              l_hi, r_hi, l_lo, r_lo;
    logic [OSPD_W-1:0] max_p, max_n, turn_p, turn_n;
    t_steer            n_steer;
    logic [OSPD_W-1:0] n_ls;
    logic [OSPD_W-1:0] n_rs;

    // sequencer
    wsos_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uop   (uop)
    );

    // handshakes
    assign o_in_ready  = uop.ready && i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign accept      = i_in_valid && o_in_ready;
    assign out_full    = r_out_valid && !i_out_ready;
    assign do_decide   = uop.decide && !out_full;

    // distance of the held sample and its skip test
    always_comb begin
        val_sat  = (r_val > VAL_FULL) ? VAL_FULL : r_val;
        near     = VAL_FULL - val_sat;
        distance = {near, 2'b00} + {2'b00, near};
        skip     = (r_val == '0)
                || ({1'b0, r_idx} >= (IDX_W+1)'(NUM_SENSORS))
                || (distance >= r_min_dist);
    end

    // one restoring division step
    always_comb begin
        rem2    = {r_rem, 1'b0};
        ge      = rem2 >= {1'b0, r_min_dist};
        rem_sub = rem2 - {1'b0, r_min_dist};
    end

    // weighted closeness and saturating sums
    always_comb begin
        modif  = 9'd256 - {1'b0, r_quo};
        prod_l = TOT_W'(weight_left(r_idx)) * TOT_W'(modif);
        prod_r = TOT_W'(weight_right(r_idx)) * TOT_W'(modif);
        sum_l  = {1'b0, r_lt} + {1'b0, prod_l};
        sum_r  = {1'b0, r_rt} + {1'b0, prod_r};
    end

    // sequencer status
    always_comb begin
        flags.accept   = accept;
        flags.skip     = skip;
        flags.div_more = (r_cnt != 3'd7);
        flags.not_last = !r_last;
        flags.out_full = out_full;
    end

    // steering decision
    always_comb begin
        thr    = {r_threshold, 8'd0};
        lim    = {r_corner, 8'd0};
        l_hi   = r_lt > thr;
        r_hi   = r_rt > thr;
        l_lo   = r_lt < thr;
        r_lo   = r_rt < thr;
        max_p  = {1'b0, r_max_speed};
        max_n  = 15'd0 - max_p;
        turn_p = {1'b0, r_turn_speed};
        turn_n = 15'd0 - turn_p;
        n_steer = ST_FWD;
        n_ls    = max_p;
        n_rs    = max_p;
        case (r_steer)
            ST_FWD: begin
                if (l_hi && r_lo) begin
                    n_steer = ST_LEFT;
                    n_ls    = turn_p;
                    n_rs    = turn_n;
                end else if (r_hi && l_lo) begin
                    n_steer = ST_RIGHT;
                    n_ls    = turn_n;
                    n_rs    = turn_p;
                end else if (l_hi && r_hi) begin
                    n_steer = ST_CORNER;
                    n_ls    = max_n;
                    n_rs    = max_p;
                end
            end
            ST_LEFT: begin
                if (l_hi || r_hi) begin
                    n_steer = ST_LEFT;
                    n_ls    = turn_p;
                    n_rs    = turn_n;
                end
            end
            ST_RIGHT: begin
                if (l_hi || r_hi) begin
                    n_steer = ST_RIGHT;
                    n_ls    = turn_n;
                    n_rs    = turn_p;
                end
            end
            ST_CORNER: begin
                if ((r_lt > lim) || (r_rt > lim)) begin
                    n_steer = ST_CORNER;
                    n_ls    = max_n;
                    n_rs    = max_p;
                end else begin
                    n_ls    = '0;
                    n_rs    = '0;
                end
            end
            default: begin
                n_steer = ST_FWD;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist   <= MIN_DIST_RST;
            r_threshold  <= THRESHOLD_RST;
            r_corner     <= CORNER_RST;
            r_max_speed  <= MAX_SPEED_RST;
            r_turn_speed <= TURN_SPD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MIN_DIST:  r_min_dist   <= i_cfg_data[DIST_W-1:0];
                CFG_THRESHOLD: r_threshold  <= i_cfg_data[THR_W-1:0];
                CFG_CORNER:    r_corner     <= i_cfg_data[THR_W-1:0];
                CFG_MAX_SPEED: r_max_speed  <= i_cfg_data[SPD_W-1:0];
                CFG_TURN_SPD:  r_turn_speed <= i_cfg_data[SPD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // control state: totals, steering state, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt        <= '0;
            r_rt        <= '0;
            r_steer     <= ST_FWD;
            r_out_valid <= 1'b0;
        end else begin
            if (do_decide) begin
                r_lt    <= '0;
                r_rt    <= '0;
                r_steer <= n_steer;
            end else if (uop.accum) begin
                r_lt <= sum_l[TOT_W] ? TOTAL_MAX : sum_l[TOT_W-1:0];
                r_rt <= sum_r[TOT_W] ? TOTAL_MAX : sum_r[TOT_W-1:0];
            end
            if (do_decide) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item capture, divider and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx  <= i_sensor_index;
            r_val  <= i_sensor_value;
            r_last <= i_last_sensor;
        end
        if (uop.setup) begin
            r_rem <= distance;
            r_quo <= '0;
            r_cnt <= '0;
        end else if (uop.div) begin
            r_rem <= ge ? rem_sub[DIST_W-1:0] : rem2[DIST_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], ge};
            r_cnt <= r_cnt + 3'd1;
        end
        if (do_decide) begin
            r_ls  <= n_ls;
            r_rs  <= n_rs;
            r_dir <= dir_code(n_steer);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_left_speed      = r_ls;
    assign o_right_speed     = r_rs;
    assign o_direction_state = r_dir;

    // a result appears only out of a decision step
    a_valid_from_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(do_decide))
        else $error("result valid without a decision step");

    // totals start from zero after every closed round
    a_totals_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(do_decide) |-> (r_lt == '0) && (r_rt == '0))
        else $error("totals not cleared after a round");

    // one item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready)
        else $error("second item taken while one is in work");

endmodule

`default_nettype wire
